// File: rtl/core/rhl_pkg.sv
// Rain history logger package: controller states, datapath operations,
// request kinds and the command/status structs between the two.
// No dependencies.
package rhl_pkg;

    localparam int KindW  = 3;
    localparam int SlotW  = 8;
    localparam int BankW  = 2;
    localparam int IndexW = 9;
    localparam int ValW   = 32;
    localparam int WeekStep = 24;

    localparam logic [KindW-1:0] KIND_TIP   = 3'd0;
    localparam logic [KindW-1:0] KIND_SLOT  = 3'd1;
    localparam logic [KindW-1:0] KIND_CLRW  = 3'd2;
    localparam logic [KindW-1:0] KIND_CLRA  = 3'd3;
    localparam logic [KindW-1:0] KIND_READ  = 3'd4;

    localparam logic [BankW-1:0] BANK_DAILY = 2'd0;
    localparam logic [BankW-1:0] BANK_YEST  = 2'd1;
    localparam logic [BankW-1:0] BANK_WEEK  = 2'd2;
    localparam logic [BankW-1:0] BANK_YEAR  = 2'd3;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_STEP,
        ST_YROLL,
        ST_YSHIFT,
        ST_WCHK,
        ST_WSHIFT,
        ST_COPY,
        ST_CLRW,
        ST_CLRA,
        ST_RDCAP,
        ST_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TIP,
        OP_STEP,
        OP_YROLL,
        OP_YSHIFT,
        OP_WSHIFT,
        OP_COPY,
        OP_CLRW_SET,
        OP_CLRW_SWEEP,
        OP_CLRA_SET,
        OP_CLRA_SWEEP,
        OP_RD_ISSUE,
        OP_RD_CAP,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_ctrl;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic             at_target;
        logic             step_rolls;
        logic             year_full_next;
        logic             week_full;
        logic             sweep_last;
    } t_status;

endpackage

// File: rtl/core/rhl_store.sv
// Rain history logger: one history store, 32-bit entries.
// Write commands are registered and land in the cycle after they are given; read data is
// registered with write-through bypass. Depends on nothing.
module rhl_store #(
    parameter int DEPTH = 240,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wlate,   // take write data from i_late when it lands
    input  logic [31:0]   i_wval,
    input  logic [31:0]   i_late,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0]   mem [DEPTH];
    logic          r_we;
    logic [AW-1:0] r_waddr;
    logic          r_wlate;
    logic [31:0]   r_wval;
    logic [31:0]   r_rdata;
    logic [31:0]   w_data;

    assign w_data  = r_wlate ? i_late : r_wval;
    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we <= 1'b0;
        end else begin
            r_we <= i_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= i_waddr;
        r_wlate <= i_wlate;
        r_wval  <= i_wval;
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem[r_waddr] <= w_data;
        end
        if (r_we && r_waddr == i_raddr) begin
            r_rdata <= w_data;
        end else begin
            r_rdata <= mem[i_raddr];
        end
    end

endmodule

// File: rtl/core/rhl_ctrl.sv
// Rain history logger controller: sequences one request at a time.
// Depends on rhl_pkg.
module rhl_ctrl
    import rhl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_free,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_ctrl.op       = OP_NONE;
        o_ctrl.in_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_ctrl.op = OP_CLRA_SWEEP;
                if (i_status.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.op = OP_LOAD;
                    n_state   = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_status.kind)
                    KIND_TIP: begin
                        o_ctrl.op = OP_TIP;
                        n_state   = ST_FINISH;
                    end
                    KIND_SLOT: begin
                        n_state = i_status.at_target ? ST_FINISH : ST_STEP;
                    end
                    KIND_CLRW: begin
                        o_ctrl.op = OP_CLRW_SET;
                        n_state   = ST_CLRW;
                    end
                    KIND_CLRA: begin
                        o_ctrl.op = OP_CLRA_SET;
                        n_state   = ST_CLRA;
                    end
                    KIND_READ: begin
                        o_ctrl.op = OP_RD_ISSUE;
                        n_state   = ST_RDCAP;
                    end
                    default: n_state = ST_FINISH;
                endcase
            end
            ST_STEP: begin
                o_ctrl.op = OP_STEP;
                n_state   = i_status.step_rolls ? ST_YROLL : ST_DISPATCH;
            end
            ST_YROLL: begin
                o_ctrl.op = OP_YROLL;
                n_state   = i_status.year_full_next ? ST_YSHIFT : ST_WCHK;
            end
            ST_YSHIFT: begin
                o_ctrl.op = OP_YSHIFT;
                if (i_status.sweep_last) n_state = ST_WCHK;
            end
            ST_WCHK: begin
                n_state = i_status.week_full ? ST_WSHIFT : ST_COPY;
            end
            ST_WSHIFT: begin
                o_ctrl.op = OP_WSHIFT;
                if (i_status.sweep_last) n_state = ST_COPY;
            end
            ST_COPY: begin
                o_ctrl.op = OP_COPY;
                if (i_status.sweep_last) n_state = ST_DISPATCH;
            end
            ST_CLRW: begin
                o_ctrl.op = OP_CLRW_SWEEP;
                if (i_status.sweep_last) n_state = ST_FINISH;
            end
            ST_CLRA: begin
                o_ctrl.op = OP_CLRA_SWEEP;
                if (i_status.sweep_last) n_state = ST_FINISH;
            end
            ST_RDCAP: begin
                o_ctrl.op = OP_RD_CAP;
                n_state   = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    o_ctrl.op = OP_EMIT;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

endmodule

// File: rtl/core/rhl_datapath.sv
// Rain history logger datapath: counters, positions, sweep counter and the
// four history stores. Depends on rhl_pkg and rhl_store.
module rhl_datapath
    import rhl_pkg::*;
#(
    parameter int DAILY_SLOTS    = 240,
    parameter int WEEKLY_SLOTS   = 168,
    parameter int YEARLY_SLOTS   = 365,
    parameter int SLOTS_PER_HOUR = 10,
    parameter int DW  = $clog2(DAILY_SLOTS),
    parameter int WPW = $clog2(WEEKLY_SLOTS + 1),
    parameter int YPW = $clog2(YEARLY_SLOTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    input  logic [KindW-1:0]  i_kind,
    input  logic [SlotW-1:0]  i_slot,
    input  logic [BankW-1:0]  i_bank,
    input  logic [IndexW-1:0] i_index,
    output t_status           o_status,
    output logic [ValW-1:0]   o_read_value,
    output logic [ValW-1:0]   o_net_tips,
    output logic [DW-1:0]     o_day_pos,
    output logic [WPW-1:0]    o_week_pos,
    output logic [YPW-1:0]    o_year_pos
);

    localparam int WA = $clog2(WEEKLY_SLOTS);
    localparam int WeekShift = WEEKLY_SLOTS / 7;
    localparam int MaxDepth0 = (DAILY_SLOTS > WEEKLY_SLOTS) ? DAILY_SLOTS : WEEKLY_SLOTS;
    localparam int MaxDepth = (MaxDepth0 > YEARLY_SLOTS) ? MaxDepth0 : YEARLY_SLOTS;
    localparam int CW = $clog2(MaxDepth);

    logic [KindW-1:0]  r_kind;
    logic [DW-1:0]     r_target;
    logic [BankW-1:0]  r_bank;
    logic [IndexW-1:0] r_index;
    logic [ValW-1:0]   r_total;
    logic [ValW-1:0]   r_offset;
    logic [ValW-1:0]   r_rv;
    logic [DW-1:0]     r_day;
    logic [WPW-1:0]    r_week;
    logic [YPW-1:0]    r_year;
    logic [DW-1:0]     r_ph;      // day position mod slots per hour
    logic [DW-1:0]     r_rem;     // remainder while dividing the slot by 24
    logic [CW-1:0]     r_sc;

    logic [ValW-1:0]   w_net;
    logic [DW-1:0]     w_target;
    logic              w_sweep;
    logic              w_last;
    logic [WA-1:0]     w_widx;

    logic              d_we,  y_we,  k_we,  a_we;
    logic [DW-1:0]     d_wa,  y_wa,  d_ra, y_ra;
    logic [WA-1:0]     k_wa,  k_ra;
    logic [YPW-1:0]    a_wa,  a_ra;
    logic              k_late, y_late, a_late;
    logic [ValW-1:0]   d_wv,  k_wv,  a_wv;
    logic [ValW-1:0]   d_rd,  y_rd,  k_rd,  a_rd;

    assign w_net    = r_total - r_offset;
    assign w_target = (32'(i_slot) >= 32'(DAILY_SLOTS)) ? DW'(DAILY_SLOTS - 1) : DW'(i_slot);
    assign w_widx   = (32'(r_week) >= 32'(WEEKLY_SLOTS)) ? WA'(r_week - WPW'(WEEKLY_SLOTS))
                                                       : WA'(r_week);

    always_comb begin
        w_sweep = 1'b1;
        w_last  = 1'b0;
        unique case (i_ctrl.op)
            OP_YSHIFT:                 w_last = (r_sc == CW'(YEARLY_SLOTS - 2));
            OP_WSHIFT:                 w_last = (r_sc == CW'(WEEKLY_SLOTS - 1));
            OP_COPY, OP_CLRW_SWEEP:    w_last = (r_sc == CW'(DAILY_SLOTS - 1));
            OP_CLRA_SWEEP:             w_last = (r_sc == CW'(MaxDepth - 1));
            default:                   w_sweep = 1'b0;
        endcase
    end

    assign o_status.kind           = r_kind;
    assign o_status.at_target      = (r_day == r_target);
    assign o_status.step_rolls     = (r_day == DW'(DAILY_SLOTS - 1));
    assign o_status.year_full_next = (r_year == YPW'(YEARLY_SLOTS - 1));
    assign o_status.week_full      = (32'(r_week) >= 32'(WEEKLY_SLOTS));
    assign o_status.sweep_last     = w_last;

    assign o_read_value = r_rv;
    assign o_net_tips   = w_net;
    assign o_day_pos    = r_day;
    assign o_week_pos   = r_week;
    assign o_year_pos   = r_year;

    // store command decode
    always_comb begin
        d_we = 1'b0; d_wa = DW'(r_sc); d_wv = '0;
        y_we = 1'b0; y_wa = DW'(r_sc); y_late = 1'b0;
        k_we = 1'b0; k_wa = WA'(r_sc); k_wv = '0; k_late = 1'b0;
        a_we = 1'b0; a_wa = YPW'(r_sc); a_wv = '0; a_late = 1'b0;
        d_ra = DW'(r_index);
        y_ra = DW'(r_index);
        k_ra = WA'(r_index);
        a_ra = YPW'(r_index);
        unique case (i_ctrl.op)
            OP_STEP: begin
                d_we = 1'b1; d_wa = r_day; d_wv = w_net;
                if (r_ph == '0) begin
                    k_we = 1'b1; k_wa = w_widx; k_wv = w_net;
                end
            end
            OP_YROLL: begin
                a_we = 1'b1; a_wa = r_year; a_wv = r_total;
            end
            OP_YSHIFT: begin
                a_we = 1'b1; a_late = 1'b1;
                a_ra = YPW'(r_sc + CW'(1));
            end
            OP_WSHIFT: begin
                k_we   = 1'b1;
                k_late = (32'(r_sc) < 32'(WEEKLY_SLOTS - WeekShift));
                k_ra   = WA'(r_sc + CW'(WeekShift));
            end
            OP_COPY: begin
                d_we = 1'b1; d_ra = DW'(r_sc);
                y_we = 1'b1; y_late = 1'b1;
            end
            OP_CLRW_SWEEP: begin
                d_we = 1'b1;
                y_we = 1'b1;
            end
            OP_CLRA_SWEEP: begin
                d_we = (32'(r_sc) < 32'(DAILY_SLOTS));
                y_we = (32'(r_sc) < 32'(DAILY_SLOTS));
                k_we = (32'(r_sc) < 32'(WEEKLY_SLOTS));
                a_we = (32'(r_sc) < 32'(YEARLY_SLOTS));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_offset <= '0;
            r_day    <= '0;
            r_week   <= '0;
            r_year   <= '0;
            r_ph     <= '0;
            r_rem    <= '0;
            r_sc     <= '0;
            r_kind   <= KIND_TIP;
            r_rv     <= '0;
        end else begin
            if (w_sweep) begin
                r_sc <= w_last ? '0 : r_sc + CW'(1);
            end else begin
                r_sc <= '0;
            end
            unique case (i_ctrl.op)
                OP_LOAD: begin
                    r_kind <= i_kind;
                    r_rv   <= '0;
                end
                OP_TIP: r_total <= r_total + 32'd1;
                OP_STEP: begin
                    if (r_ph == '0) r_week <= r_week + WPW'(1);
                    r_ph <= (r_ph == DW'(SLOTS_PER_HOUR - 1)) ? '0 : r_ph + DW'(1);
                    if (!o_status.step_rolls) r_day <= r_day + DW'(1);
                end
                OP_YROLL: begin
                    r_year <= o_status.year_full_next ? r_year : r_year + YPW'(1);
                end
                OP_WSHIFT: begin
                    if (w_last) r_week <= WPW'(WEEKLY_SLOTS - WeekShift);
                end
                OP_COPY: begin
                    if (w_last) begin
                        r_day <= '0;
                        r_ph  <= '0;
                    end
                end
                OP_CLRW_SET: r_offset <= r_total;
                OP_CLRA_SET: begin
                    r_total  <= '0;
                    r_offset <= '0;
                    r_day    <= r_target;
                    r_ph     <= r_target;
                    r_rem    <= r_target;
                    r_week   <= '0;
                    r_year   <= '0;
                end
                OP_CLRA_SWEEP: begin
                    // one subtraction per cycle for slot/24 and slot mod hour
                    if (32'(r_rem) >= 32'(WeekStep)) begin
                        r_rem  <= r_rem - DW'(WeekStep);
                        r_week <= r_week + WPW'(1);
                    end
                    if (32'(r_ph) >= 32'(SLOTS_PER_HOUR)) begin
                        r_ph <= r_ph - DW'(SLOTS_PER_HOUR);
                    end
                end
                OP_RD_CAP: begin
                    unique case (r_bank)
                        BANK_DAILY: r_rv <= (32'(r_index) < 32'(DAILY_SLOTS))  ? d_rd : '0;
                        BANK_YEST:  r_rv <= (32'(r_index) < 32'(DAILY_SLOTS))  ? y_rd : '0;
                        BANK_WEEK:  r_rv <= (32'(r_index) < 32'(WEEKLY_SLOTS)) ? k_rd : '0;
                        default:    r_rv <= (32'(r_index) < 32'(YEARLY_SLOTS)) ? a_rd : '0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == OP_LOAD) begin
            r_target <= w_target;
            r_bank   <= i_bank;
            r_index  <= i_index;
        end
    end

    rhl_store #(.DEPTH(DAILY_SLOTS), .AW(DW)) u_daily (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(d_we), .i_waddr(d_wa),
        .i_wlate(1'b0), .i_wval(d_wv), .i_late(d_rd), .i_raddr(d_ra), .o_rdata(d_rd)
    );

    rhl_store #(.DEPTH(DAILY_SLOTS), .AW(DW)) u_yest (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(y_we), .i_waddr(y_wa),
        .i_wlate(y_late), .i_wval('0), .i_late(d_rd), .i_raddr(y_ra), .o_rdata(y_rd)
    );

    rhl_store #(.DEPTH(WEEKLY_SLOTS), .AW(WA)) u_week (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(k_we), .i_waddr(k_wa),
        .i_wlate(k_late), .i_wval(k_wv), .i_late(k_rd), .i_raddr(k_ra), .o_rdata(k_rd)
    );

    rhl_store #(.DEPTH(YEARLY_SLOTS), .AW(YPW)) u_year (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(a_we), .i_waddr(a_wa),
        .i_wlate(a_late), .i_wval(a_wv), .i_late(a_rd), .i_raddr(a_ra), .o_rdata(a_rd)
    );

endmodule

// File: rtl/core/rain_history_logger_unit.sv
// Rain history logger top level: stream ports, result register,
// controller and datapath. Depends on rhl_pkg, rhl_ctrl, rhl_datapath.
//
// Each request transfer carries one kind in tuser: bucket tip, slot update,
// clear week, clear all or read entry, and gives exactly one result transfer
// with the read value, net tip count and the three history positions after
// the request. One request is worked on at a time; a new request transfer is
// taken as soon as the previous one is finished, even while its result still
// waits in the output register. After reset the block runs a clearing pass
// over all four stores, up to the largest of DAILY_SLOTS, WEEKLY_SLOTS and
// YEARLY_SLOTS entries, with tready low. Clear week sweeps the daily and
// yesterday stores, and clear all sweeps all four stores. A slot update
// steps one slot at a time, and each day roll it crosses writes the year
// entry, then runs the year shift (when the year store is full), the week
// shift (when the week store is full) and the copy into yesterday, sweeps
// that the single write port of each store makes walk one entry per cycle.
module rain_history_logger_unit
    import rhl_pkg::*;
#(
    parameter int DAILY_SLOTS    = 240,
    parameter int WEEKLY_SLOTS   = 168,
    parameter int YEARLY_SLOTS   = 365,
    parameter int SLOTS_PER_HOUR = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // slot[7:0], bank[9:8], entry_index[18:10], zero pad
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [((64 + $clog2(DAILY_SLOTS) + $clog2(WEEKLY_SLOTS + 1)
                   + $clog2(YEARLY_SLOTS) + 7) / 8) * 8 - 1:0] m_axis_tdata
        // read_value[31:0], net_tips[63:32], day_position, week_position,
        // year_position, zero pad
);

    localparam int DW  = $clog2(DAILY_SLOTS);
    localparam int WPW = $clog2(WEEKLY_SLOTS + 1);
    localparam int YPW = $clog2(YEARLY_SLOTS);
    localparam int OW  = 64 + DW + WPW + YPW;
    localparam int OWP = ((OW + 7) / 8) * 8;

    t_ctrl           w_ctrl;
    t_status         w_status;
    logic            w_out_free;
    logic [ValW-1:0] w_rv;
    logic [ValW-1:0] w_net;
    logic [DW-1:0]   w_day;
    logic [WPW-1:0]  w_week;
    logic [YPW-1:0]  w_year;

    logic            r_out_valid;
    logic [OW-1:0]   r_out_data;

    // the result register is free when empty or being drained this cycle
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_ctrl.in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OWP'(r_out_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result until the downstream side takes the transfer
    always_ff @(posedge i_clk) begin
        if (w_ctrl.op == OP_EMIT) begin
            r_out_data <= {w_year, w_week, w_day, w_net, w_rv};
        end
    end

    rhl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    rhl_datapath #(
        .DAILY_SLOTS    (DAILY_SLOTS),
        .WEEKLY_SLOTS   (WEEKLY_SLOTS),
        .YEARLY_SLOTS   (YEARLY_SLOTS),
        .SLOTS_PER_HOUR (SLOTS_PER_HOUR),
        .DW             (DW),
        .WPW            (WPW),
        .YPW            (YPW)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_kind       (s_axis_tuser),
        .i_slot       (s_axis_tdata[7:0]),
        .i_bank       (s_axis_tdata[9:8]),
        .i_index      (s_axis_tdata[18:10]),
        .o_status     (w_status),
        .o_read_value (w_rv),
        .o_net_tips   (w_net),
        .o_day_pos    (w_day),
        .o_week_pos   (w_week),
        .o_year_pos   (w_year)
    );

endmodule

// File: tb/sv/rain_history_logger_checker.sv
// Checker for the rain history logger: watches both stream channels,
// predicts each result from the accepted requests and compares it.
// Depends on rhl_pkg for request kinds and store selectors.
module rain_history_logger_checker
    import rhl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_tvalid,
    input  logic        i_req_tready,
    input  logic [23:0] i_req_tdata,
    input  logic [2:0]  i_req_tuser,
    input  logic        i_res_tvalid,
    input  logic        i_res_tready,
    input  logic [95:0] i_res_tdata,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DayN  = 240;
    localparam int WeekN = 168;
    localparam int YearN = 365;
    localparam int Hour  = 10;
    localparam int WeekShift = WeekN / 7;

    typedef struct packed {
        logic [31:0] read_value;
        logic [31:0] net_tips;
        logic [7:0]  day_position;
        logic [7:0]  week_position;
        logic [8:0]  year_position;
    } t_log_result;

    logic [31:0] tips;
    logic [31:0] tips_base;
    logic [31:0] day_log  [DayN];
    logic [31:0] prev_log [DayN];
    logic [31:0] week_log [WeekN];
    logic [31:0] year_log [YearN];
    int          day_at;
    int          week_at;
    int          year_at;
    t_log_result log_results_due[$];

    // close the day: log the gross count, age the week, move today to yesterday
    task automatic roll_day();
        year_log[year_at % YearN] = tips;
        year_at++;
        if (year_at >= YearN) begin
            for (int i = 0; i < YearN - 1; i++) year_log[i] = year_log[i + 1];
            year_at = YearN - 1;
        end
        if (week_at >= WeekN) begin
            for (int i = 0; i < WeekN - WeekShift; i++) week_log[i] = week_log[i + WeekShift];
            for (int i = WeekN - WeekShift; i < WeekN; i++) week_log[i] = '0;
            week_at = WeekN - WeekShift;
        end
        for (int i = 0; i < DayN; i++) begin
            prev_log[i] = day_log[i];
            day_log[i]  = '0;
        end
        day_at = 0;
    endtask

    task automatic advance_slot();
        logic [31:0] net;
        net = tips - tips_base;
        day_log[day_at % DayN] = net;
        if (day_at % Hour == 0) begin
            week_log[week_at % WeekN] = net;
            week_at++;
        end
        day_at++;
        if (day_at >= DayN) roll_day();
    endtask

    task automatic clear_logs(input bit all_stores);
        for (int i = 0; i < DayN; i++) begin
            day_log[i]  = '0;
            prev_log[i] = '0;
        end
        if (all_stores) begin
            for (int i = 0; i < WeekN; i++) week_log[i] = '0;
            for (int i = 0; i < YearN; i++) year_log[i] = '0;
        end
    endtask

    task automatic log_request(input logic [2:0] kind, input logic [23:0] fields);
        logic [7:0]  slot;
        logic [1:0]  bank;
        logic [8:0]  idx;
        int          target;
        int          guard;
        t_log_result res;
        slot = fields[7:0];
        bank = fields[9:8];
        idx  = fields[18:10];
        target = (slot >= DayN) ? DayN - 1 : int'(slot);
        res.read_value = '0;
        case (kind)
            KIND_TIP: tips++;
            KIND_SLOT: begin
                guard = 0;
                while (day_at != target && guard < 2 * DayN + 2) begin
                    advance_slot();
                    guard++;
                end
            end
            KIND_CLRW: begin
                clear_logs(1'b0);
                tips_base = tips;
            end
            KIND_CLRA: begin
                clear_logs(1'b1);
                day_at    = target;
                week_at   = target / WeekStep;
                year_at   = 0;
                tips      = '0;
                tips_base = '0;
            end
            KIND_READ: begin
                case (bank)
                    BANK_DAILY: res.read_value = (idx < DayN)  ? day_log[idx]  : '0;
                    BANK_YEST:  res.read_value = (idx < DayN)  ? prev_log[idx] : '0;
                    BANK_WEEK:  res.read_value = (idx < WeekN) ? week_log[idx] : '0;
                    default:    res.read_value = (idx < YearN) ? year_log[idx] : '0;
                endcase
            end
            default: ;
        endcase
        res.net_tips      = tips - tips_base;
        res.day_position  = day_at[7:0];
        res.week_position = week_at[7:0];
        res.year_position = year_at[8:0];
        log_results_due.push_back(res);
    endtask

    task automatic compare_result(input logic [95:0] data);
        t_log_result want;
        t_log_result got;
        if (log_results_due.size() == 0) begin
            $error("result transfer with no request outstanding: %h", data);
            o_errors++;
            return;
        end
        want = log_results_due.pop_front();
        got  = {data[31:0], data[63:32], data[71:64], data[79:72], data[88:80]};
        if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
            o_errors++;
        end
        if (got.net_tips !== want.net_tips) begin
            $error("net_tips: expected %0d, got %0d", want.net_tips, got.net_tips);
            o_errors++;
        end
        if (got.day_position !== want.day_position) begin
            $error("day_position: expected %0d, got %0d", want.day_position,
                   got.day_position);
            o_errors++;
        end
        if (got.week_position !== want.week_position) begin
            $error("week_position: expected %0d, got %0d", want.week_position,
                   got.week_position);
            o_errors++;
        end
        if (got.year_position !== want.year_position) begin
            $error("year_position: expected %0d, got %0d", want.year_position,
                   got.year_position);
            o_errors++;
        end
    endtask

    initial begin
        o_errors  = 0;
        tips      = '0;
        tips_base = '0;
        day_at    = 0;
        week_at   = 0;
        year_at   = 0;
        clear_logs(1'b1);
    end

    assign o_pending = log_results_due.size();

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res_tvalid && i_res_tready) compare_result(i_res_tdata);
            if (i_req_tvalid && i_req_tready) log_request(i_req_tuser, i_req_tdata);
        end
    end

endmodule

// File: tb/sv/rain_history_logger_unit_tb.sv
// Testbench top for the rain history logger: clock, reset, request and
// result stream drivers, verdict. Depends on rhl_pkg,
// rain_history_logger_unit and rain_history_logger_checker.
module rain_history_logger_unit_tb
    import rhl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // slot[7:0], bank[9:8], entry_index[18:10]
    logic [2:0]  s_axis_tuser = '0;   // req_type[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // read_value, net_tips, day, week, year positions
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          steady = 1'b0;       // no idling on either side while set

    always #5 i_clk = ~i_clk;

    rain_history_logger_unit DUT (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    rain_history_logger_checker checker_i (
        .i_clk, .i_rst_n,
        .i_req_tvalid(s_axis_tvalid), .i_req_tready(s_axis_tready),
        .i_req_tdata(s_axis_tdata), .i_req_tuser(s_axis_tuser),
        .i_res_tvalid(m_axis_tvalid), .i_res_tready(m_axis_tready),
        .i_res_tdata(m_axis_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    // stall the result side at random, except during the steady stretch
    always @(negedge i_clk) begin
        if (i_rst_n) m_axis_tready <= steady || ($urandom_range(99) >= 15);
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one request transfer; hold valid high across back-to-back transfers
    task automatic send_request(input logic [2:0] kind, input logic [7:0] slot,
                                input logic [1:0] bank, input logic [8:0] idx);
        if (!steady && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'b0, idx, bank, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            send_request(KIND_TIP, 8'($urandom), 2'($urandom), 9'($urandom));
        else if (pick < 55)
            send_request(KIND_SLOT, 8'($urandom_range(255)), 2'($urandom), 9'($urandom));
        else if (pick < 88)
            send_request(KIND_READ, 8'($urandom), 2'($urandom), 9'($urandom_range(511)));
        else if (pick < 92)
            send_request(KIND_CLRW, 8'($urandom), 2'($urandom), 9'($urandom));
        else if (pick < 94)
            send_request(KIND_CLRA, 8'($urandom_range(255)), 2'($urandom), 9'($urandom));
        else
            send_request(3'($urandom_range(5, 7)), 8'($urandom), 2'($urandom),
                         9'($urandom));
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every kind, store edges, slot saturation, equal and behind slots
        send_request(KIND_TIP, 8'd0, 2'd0, 9'd0);
        send_request(KIND_TIP, 8'd0, 2'd0, 9'd0);
        send_request(KIND_SLOT, 8'd25, 2'd0, 9'd0);
        send_request(KIND_SLOT, 8'd25, 2'd0, 9'd0);
        send_request(KIND_READ, 8'd0, BANK_DAILY, 9'd0);
        send_request(KIND_READ, 8'd0, BANK_DAILY, 9'd239);
        send_request(KIND_READ, 8'd0, BANK_DAILY, 9'd240);
        send_request(KIND_READ, 8'd0, BANK_WEEK, 9'd2);
        send_request(KIND_READ, 8'd0, BANK_WEEK, 9'd168);
        send_request(KIND_SLOT, 8'd255, 2'd0, 9'd0);
        send_request(KIND_SLOT, 8'd3, 2'd0, 9'd0);
        send_request(KIND_READ, 8'd0, BANK_YEST, 9'd239);
        send_request(KIND_READ, 8'd0, BANK_YEAR, 9'd0);
        send_request(KIND_READ, 8'd0, BANK_YEAR, 9'd364);
        send_request(KIND_READ, 8'd0, BANK_YEAR, 9'd511);
        send_request(KIND_CLRW, 8'd0, 2'd0, 9'd0);
        send_request(3'd5, 8'hff, 2'd3, 9'h1ff);
        send_request(3'd6, 8'd0, 2'd0, 9'd0);
        send_request(3'd7, 8'd0, 2'd0, 9'd0);
        send_request(KIND_CLRA, 8'd255, 2'd0, 9'd0);
        send_request(KIND_READ, 8'd0, BANK_YEST, 9'd0);

        // hold off until every result is back
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);

        // fill the year: each slot update lands one slot behind the position,
        // so nearly every one crosses a day roll; tips and reads between; runs
        // past the yearly wrap
        send_request(KIND_CLRA, 8'd239, 2'd0, 9'd0);
        for (int d = 0; d < 385; d++) begin
            steady = (d >= 100 && d < 140);
            send_request(KIND_SLOT, 8'((478 - d) % 240), 2'd0, 9'd0);
            if ($urandom_range(3) == 0) send_request(KIND_TIP, 8'd0, 2'd0, 9'd0);
            if ($urandom_range(3) == 0)
                send_request(KIND_READ, 8'd0, 2'($urandom), 9'($urandom_range(511)));
        end
        steady = 1'b0;
        for (int i = 0; i < 20; i++)
            send_request(KIND_READ, 8'd0, 2'($urandom), 9'($urandom_range(511)));

        // mixed random traffic
        for (int i = 0; i < 130; i++) send_random();
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (50) @(negedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
